// ===== rtl/core/pow2_size_class_allocator_core_assert.svh =====
// assertion macros for the size class allocator
`ifndef POW2_SIZE_CLASS_ALLOCATOR_CORE_ASSERT_SVH
`define POW2_SIZE_CLASS_ALLOCATOR_CORE_ASSERT_SVH

// checked only while out of reset
`define POW2SC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define POW2SC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/pow2sc_pkg.sv =====
`default_nettype none

package pow2sc_pkg;

  // default sizing of the heap and the classes
  localparam int HEAP_BYTES_DEF      = 65536;
  localparam int NUM_CLASSES_DEF     = 13;
  localparam int MIN_BLOCK_SHIFT_DEF = 3;

  // field widths
  localparam int SIZE_W   = 16;
  localparam int ADDR_W   = 16;
  localparam int STAT_W   = 2;
  localparam int CLS_W    = 5;
  localparam int BITLEN_W = 5;

  // large threshold after reset
  localparam logic [SIZE_W-1:0] THR_RESET = 16'h8000;

  // request kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // result codes
  localparam logic [STAT_W-1:0] ST_ALLOC = 2'd0;
  localparam logic [STAT_W-1:0] ST_FREED = 2'd1;
  localparam logic [STAT_W-1:0] ST_OOM   = 2'd2;
  localparam logic [STAT_W-1:0] ST_LARGE = 2'd3;

  typedef struct packed {
    logic              kind;
    logic [SIZE_W-1:0] req_size;
    logic [ADDR_W-1:0] block_addr;
  } in_beat_t;

  typedef struct packed {
    logic [ADDR_W-1:0] result_addr;
    logic [STAT_W-1:0] status;
  } out_beat_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic exec;
  } ctrl_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/pow2sc_ctrl.sv =====
`default_nettype none

module pow2sc_ctrl (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    start,
  output logic                   busy,
  output logic                   out_valid,
  output pow2sc_pkg::ctrl_cmd_t  cmd
);
  import pow2sc_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  // next state: capture from idle, then execute
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy        = (state_r == S_EXEC);
  assign out_valid   = out_valid_r;
  assign cmd.capture = start && (state_r == S_IDLE);
  assign cmd.exec    = (state_r == S_EXEC);

endmodule

`default_nettype wire

// ===== rtl/core/pow2sc_dp.sv =====
`default_nettype none

module pow2sc_dp #(
  parameter int HEAP_BYTES      = pow2sc_pkg::HEAP_BYTES_DEF,
  parameter int NUM_CLASSES     = pow2sc_pkg::NUM_CLASSES_DEF,
  parameter int MIN_BLOCK_SHIFT = pow2sc_pkg::MIN_BLOCK_SHIFT_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  pow2sc_pkg::ctrl_cmd_t               cmd,
  input  pow2sc_pkg::in_beat_t                in_req,
  input  wire                                 cfg_we,
  input  wire  [pow2sc_pkg::SIZE_W-1:0]       cfg_wdata,
  output pow2sc_pkg::out_beat_t               out_res
);
  import pow2sc_pkg::*;

  localparam int LINK_DEPTH = HEAP_BYTES >> MIN_BLOCK_SHIFT;
  localparam int SLOT_W     = $clog2(LINK_DEPTH);
  localparam int ASLOT_W    = ADDR_W - MIN_BLOCK_SHIFT;
  localparam int CMP_W      = ((SLOT_W > ASLOT_W) ? SLOT_W : ASLOT_W) + 1;
  localparam int BP_W       = $clog2(HEAP_BYTES) + 1;
  localparam int SZ_W       = (BP_W > 17) ? BP_W : 17;
  localparam int HIDX_W     = $clog2(NUM_CLASSES);
  localparam int ENT_W      = SLOT_W + 1;

  // large threshold register
  logic [SIZE_W-1:0] thr_r;

  // class heads, valid bits cleared by reset
  logic [SLOT_W-1:0] head_slot_r [NUM_CLASSES];
  logic              head_vld_r  [NUM_CLASSES];

  logic [BP_W-1:0]   bump_r;

  // link memory: {valid, next slot}
  logic [ENT_W-1:0]  link_mem [LINK_DEPTH];
  logic [ENT_W-1:0]  link_rd_r;

  // captured request
  in_beat_t          req_r;
  logic [CLS_W-1:0]  cls_r;
  logic              large_r;
  logic [SLOT_W-1:0] cur_slot_r;
  logic              cur_vld_r;
  out_beat_t         out_res_r;

  // class lookup on the incoming size
  logic [SIZE_W-1:0]   sz1;
  logic [SIZE_W-1:0]   vm1;
  logic [BITLEN_W-1:0] bitlen;
  logic [CLS_W-1:0]    cls_in;
  logic                cls_ok_in;
  logic [HIDX_W-1:0]   hidx_in;
  logic [SLOT_W-1:0]   in_head_slot;
  logic                in_head_vld;

  always_comb begin
    sz1    = (in_req.req_size == '0) ? SIZE_W'(1) : in_req.req_size;
    vm1    = sz1 - SIZE_W'(1);
    bitlen = '0;
    for (int i = 0; i < SIZE_W; i++) begin
      if (vm1[i]) begin
        bitlen = BITLEN_W'(i + 1);
      end
    end
    cls_in    = (bitlen > BITLEN_W'(MIN_BLOCK_SHIFT)) ?
                CLS_W'(bitlen - BITLEN_W'(MIN_BLOCK_SHIFT)) : '0;
    cls_ok_in = (cls_in < CLS_W'(NUM_CLASSES));
    hidx_in   = cls_ok_in ? cls_in[HIDX_W-1:0] : '0;
    in_head_slot = head_slot_r[hidx_in];
    in_head_vld  = cls_ok_in && head_vld_r[hidx_in];
  end

  // execute-cycle decisions
  logic [HIDX_W-1:0] hidx;
  logic [ASLOT_W-1:0] free_slot;
  logic              free_in_range;
  logic [SZ_W-1:0]   bsize;
  logic [SZ_W-1:0]   left;
  logic [31:0]       pop_addr;
  logic [31:0]       bump_addr;
  logic              do_pop;
  logic              do_bump;
  logic              do_push;
  out_beat_t         res;

  always_comb begin
    hidx          = cls_r[HIDX_W-1:0];
    free_slot     = req_r.block_addr[ADDR_W-1:MIN_BLOCK_SHIFT];
    free_in_range = (CMP_W'(free_slot) < CMP_W'(LINK_DEPTH));
    bsize         = SZ_W'(1) << (6'(cls_r) + 6'(MIN_BLOCK_SHIFT));
    left          = SZ_W'(HEAP_BYTES) - SZ_W'(bump_r);
    pop_addr      = 32'(cur_slot_r) << MIN_BLOCK_SHIFT;
    bump_addr     = 32'(bump_r);
    do_pop        = 1'b0;
    do_bump       = 1'b0;
    do_push       = 1'b0;
    res.result_addr = '0;
    res.status      = ST_LARGE;
    if (!large_r) begin
      if (req_r.kind == KIND_ALLOC) begin
        if (cur_vld_r) begin
          do_pop          = 1'b1;
          res.result_addr = pop_addr[ADDR_W-1:0];
          res.status      = ST_ALLOC;
        end else if (left >= bsize) begin
          do_bump         = 1'b1;
          res.result_addr = bump_addr[ADDR_W-1:0];
          res.status      = ST_ALLOC;
        end else begin
          res.status = ST_OOM;
        end
      end else begin
        do_push    = free_in_range;
        res.status = ST_FREED;
      end
    end
  end

  // threshold, bump pointer and head valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= THR_RESET;
      bump_r <= '0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        head_vld_r[i] <= 1'b0;
      end
    end else begin
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
      if (cmd.exec && do_bump) begin
        bump_r <= BP_W'(SZ_W'(bump_r) + bsize);
      end
      if (cmd.exec && do_pop) begin
        head_vld_r[hidx] <= link_rd_r[SLOT_W];
      end
      if (cmd.exec && do_push) begin
        head_vld_r[hidx] <= 1'b1;
      end
    end
  end

  // head slots
  always_ff @(posedge clk) begin
    if (cmd.exec && do_pop) begin
      head_slot_r[hidx] <= link_rd_r[SLOT_W-1:0];
    end
    if (cmd.exec && do_push) begin
      head_slot_r[hidx] <= SLOT_W'(free_slot);
    end
  end

  // link memory: read at capture, write on free
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      link_rd_r <= link_mem[in_head_slot];
    end
    if (cmd.exec && do_push) begin
      link_mem[SLOT_W'(free_slot)] <= {head_vld_r[hidx], head_slot_r[hidx]};
    end
  end

  // capture registers and result beat
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r      <= in_req;
      cls_r      <= cls_in;
      large_r    <= (sz1 >= thr_r) || !cls_ok_in;
      cur_slot_r <= in_head_slot;
      cur_vld_r  <= in_head_vld;
    end
    if (cmd.exec) begin
      out_res_r <= res;
    end
  end

  assign out_res = out_res_r;

endmodule

`default_nettype wire

// ===== rtl/core/pow2_size_class_allocator_core.sv =====
// Power-of-two size class allocator over one heap region.
// Request channel: drive in_req (kind, req_size, block_addr) and raise start;
// the beat is taken at a rising edge with start high and busy low.
// Result channel: out_valid is high for exactly one cycle with out_res
// (result_addr, status); the receiver must take it then, it cannot stall.
// Sequence: the cycle after acceptance executes, and the result is registered
// at its end and is on the ports in the cycle after it.
// busy is high in the execute cycle after acceptance, so no new request is taken
// while one executes; this is set by the class head read plus link memory
// read at capture and the head write-back in the execute cycle.
// Configuration: cfg_we with cfg_wdata writes the large threshold at once;
// write it only while no request is in flight.
// Reset (rst_n low, synchronous) empties every class list, clears the bump
// pointer, sets the threshold to 32768 and drops busy and out_valid. The
// link memory is not cleared; an entry is only used after a free wrote it.
`default_nettype none

module pow2_size_class_allocator_core #(
  parameter int HEAP_BYTES      = pow2sc_pkg::HEAP_BYTES_DEF,
  parameter int NUM_CLASSES     = pow2sc_pkg::NUM_CLASSES_DEF,
  parameter int MIN_BLOCK_SHIFT = pow2sc_pkg::MIN_BLOCK_SHIFT_DEF
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            start,
  output logic                           busy,
  input  pow2sc_pkg::in_beat_t           in_req,
  output logic                           out_valid,
  output pow2sc_pkg::out_beat_t          out_res,
  input  wire                            cfg_we,
  input  wire  [pow2sc_pkg::SIZE_W-1:0]  cfg_wdata
);
  import pow2sc_pkg::*;

  ctrl_cmd_t cmd;

  // sequencer
  pow2sc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // class lists, bump pointer and link memory
  pow2sc_dp #(
    .HEAP_BYTES      (HEAP_BYTES),
    .NUM_CLASSES     (NUM_CLASSES),
    .MIN_BLOCK_SHIFT (MIN_BLOCK_SHIFT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_req    (in_req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_res   (out_res)
  );

  // result beat that is not an allocation
  logic non_alloc_beat;
  assign non_alloc_beat = out_valid && (out_res.status != ST_ALLOC);

  `include "pow2_size_class_allocator_core_assert.svh"

  // reset leaves the block idle with no result pending
  `POW2SC_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !busy && !out_valid, "not idle after reset")
  // an accepted beat raises busy, then busy drops as its result is given
  `POW2SC_ASSERT(a_accept_busy, start && !busy |=> busy, "accepted beat did not go busy")
  `POW2SC_ASSERT(a_exec_result, busy |=> !busy && out_valid, "execute gave no result")
  // only an allocation carries an address
  `POW2SC_ASSERT(a_addr_zero, non_alloc_beat |-> out_res.result_addr == '0, "stray address")

endmodule

`default_nettype wire

// ===== dv/pow2_size_class_allocator_core_checker.sv =====
module pow2_size_class_allocator_core_checker
  import pow2sc_pkg::*;
(
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  input  wire               busy,
  input  in_beat_t          in_req,
  input  wire               out_valid,
  input  out_beat_t         out_res,
  input  wire               cfg_we,
  input  wire  [SIZE_W-1:0] cfg_wdata,
  output int                fail_count,
  output int                answers_owed
);

  localparam int HEAP    = HEAP_BYTES_DEF;
  localparam int CLASSES = NUM_CLASSES_DEF;
  localparam int SHIFT   = MIN_BLOCK_SHIFT_DEF;
  localparam int SLOTS   = HEAP >> SHIFT;
  localparam int PRINT_CAP = 40;

  // mirrored allocator state
  logic [SIZE_W-1:0] large_thr;
  logic [13:0]       head_slot [CLASSES];
  logic              head_live [CLASSES];
  logic [16:0]       bump;
  logic [13:0]       link_slot [SLOTS];
  logic              link_live [SLOTS];

  // answers the block owes, oldest first
  out_beat_t answers_due[$];

  task automatic report_mismatch(input string what);
    if (fail_count < PRINT_CAP) begin
      $display("ERROR @%0t: %s", $time, what);
    end
    fail_count++;
  endtask

  // power-of-two class of a byte size, 8 bytes being class 0
  function automatic int unsigned class_of(input int unsigned sz);
    int unsigned v;
    int unsigned c;
    v = sz - 1;
    c = 0;
    while (v > (1 << SHIFT) - 1) begin
      v = v >> 1;
      c++;
    end
    return c;
  endfunction

  // answer to one request; updates the mirrored lists and bump pointer
  function automatic out_beat_t serve_request(input in_beat_t req);
    out_beat_t   ans;
    int unsigned sz;
    int unsigned cls;
    int unsigned slot;
    int unsigned bsize;
    int unsigned room;
    ans.result_addr = '0;
    sz = (req.req_size == 0) ? 1 : req.req_size;
    cls = class_of(sz);
    if (sz >= large_thr || cls >= CLASSES) begin
      ans.status = ST_LARGE;
    end else if (req.kind == KIND_ALLOC) begin
      if (head_live[cls]) begin
        // pop the class list
        slot = head_slot[cls];
        ans.result_addr = 16'(slot << SHIFT);
        if (slot < SLOTS) begin
          head_slot[cls] = link_slot[slot];
          head_live[cls] = link_live[slot];
        end else begin
          head_live[cls] = 1'b0;
        end
        ans.status = ST_ALLOC;
      end else begin
        // carve from the bump pointer
        bsize = 1 << (cls + SHIFT);
        room = (bump <= HEAP) ? HEAP - bump : 0;
        if (room >= bsize) begin
          ans.result_addr = 16'(bump);
          bump = 17'(bump + bsize);
          ans.status = ST_ALLOC;
        end else begin
          ans.status = ST_OOM;
        end
      end
    end else begin
      // push onto the class list, low address bits dropped
      slot = req.block_addr >> SHIFT;
      if (slot < SLOTS) begin
        link_slot[slot] = head_slot[cls];
        link_live[slot] = head_live[cls];
        head_slot[cls] = 14'(slot);
        head_live[cls] = 1'b1;
      end
      ans.status = ST_FREED;
    end
    return ans;
  endfunction

  // watch both channels and the config port
  always @(posedge clk) begin
    out_beat_t want;
    if (!rst_n) begin
      large_thr = THR_RESET;
      bump = '0;
      for (int i = 0; i < CLASSES; i++) begin
        head_slot[i] = '0;
        head_live[i] = 1'b0;
      end
      for (int i = 0; i < SLOTS; i++) begin
        link_slot[i] = '0;
        link_live[i] = 1'b0;
      end
      answers_due.delete();
    end else begin
      // result beat against the oldest answer owed
      if (out_valid) begin
        if (answers_due.size() == 0) begin
          report_mismatch($sformatf("result beat addr %h status %0d with nothing owed",
                                    out_res.result_addr, out_res.status));
        end else begin
          want = answers_due.pop_front();
          if (out_res.result_addr !== want.result_addr) begin
            report_mismatch($sformatf("result_addr %h, expected %h",
                                      out_res.result_addr, want.result_addr));
          end
          if (out_res.status !== want.status) begin
            report_mismatch($sformatf("status %0d, expected %0d",
                                      out_res.status, want.status));
          end
        end
      end
      if (cfg_we) begin
        large_thr = cfg_wdata;
      end
      // request beat taken
      if (start && !busy) begin
        want = serve_request(in_req);
        answers_due = {answers_due, want};
      end
    end
    answers_owed <= answers_due.size();
  end

endmodule

// ===== dv/pow2_size_class_allocator_core_tb.sv =====
module pow2_size_class_allocator_core_tb;
  import pow2sc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_BEATS = 210;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
  } live_block_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  in_beat_t          in_req = '0;
  logic              cfg_we = 1'b0;
  logic [SIZE_W-1:0] cfg_wdata = THR_RESET;
  wire               busy;
  wire               out_valid;
  out_beat_t         out_res;
  int                fail_count;
  int                answers_owed;
  int                cycles = 0;
  logic              quiet = 1'b0;

  // blocks handed out and not yet freed, for well-formed frees
  live_block_t       live_blocks[$];
  logic [SIZE_W-1:0] sizes_in_flight[$];

  pow2_size_class_allocator_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  pow2_size_class_allocator_core_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_req       (in_req),
    .out_valid    (out_valid),
    .out_res      (out_res),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .answers_owed (answers_owed)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("pow2_size_class_allocator_core_tb failed");
      $finish;
    end
  end

  // collect granted blocks mid-cycle, away from the driving edge
  always @(negedge clk) begin
    logic [SIZE_W-1:0] sz;
    live_block_t       got;
    if (rst_n && out_valid && sizes_in_flight.size() > 0) begin
      sz = sizes_in_flight.pop_front();
      if (out_res.status == ST_ALLOC) begin
        got.addr = out_res.result_addr;
        got.size = sz;
        live_blocks = {live_blocks, got};
      end
    end
  end

  // sender idle time: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    if (quiet) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 40);
  endfunction

  // one request beat; returns at the edge that takes it or after the gap
  task automatic send_beat(input logic kind, input logic [SIZE_W-1:0] sz,
                           input logic [ADDR_W-1:0] addr);
    in_beat_t b;
    int       gap;
    b.kind = kind;
    b.req_size = sz;
    b.block_addr = addr;
    in_req <= b;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    sizes_in_flight = {sizes_in_flight, sz};
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold off until every answer has come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (answers_owed != 0) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [SIZE_W-1:0] thr);
    cfg_wdata <= thr;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // request size skewed toward small blocks
  function automatic logic [SIZE_W-1:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      return SIZE_W'($urandom_range(0, 64));
    end else if (r < 70) begin
      return SIZE_W'($urandom_range(65, 1024));
    end else if (r < 85) begin
      return SIZE_W'($urandom_range(1025, 8192));
    end else if (r < 95) begin
      return SIZE_W'($urandom_range(8193, 32768));
    end
    return SIZE_W'($urandom_range(0, 65535));
  endfunction

  // mostly alloc and matching free, some noise
  task automatic random_beat();
    live_block_t blk;
    int          r;
    int          idx;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      send_beat(1'($urandom), SIZE_W'($urandom), ADDR_W'($urandom));
    end else if (live_blocks.size() > 0 && (r < 55 || live_blocks.size() > 300)) begin
      idx = $urandom_range(0, live_blocks.size() - 1);
      blk = live_blocks[idx];
      live_blocks.delete(idx);
      if ($urandom_range(0, 3) == 0) begin
        blk.addr[2:0] = 3'($urandom);
      end
      send_beat(KIND_FREE, blk.size, blk.addr);
    end else begin
      send_beat(KIND_ALLOC, pick_size(), ADDR_W'($urandom));
    end
  endtask

  initial begin
    logic [SIZE_W-1:0] thr;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: small classes from the bump pointer, zero size, large sizes
    send_beat(KIND_ALLOC, 16'd0, 16'h0000);
    send_beat(KIND_ALLOC, 16'd1, 16'hFFFF);
    send_beat(KIND_ALLOC, 16'd8, 16'h0000);
    send_beat(KIND_ALLOC, 16'd9, 16'h0000);
    send_beat(KIND_ALLOC, 16'd16, 16'h0000);
    send_beat(KIND_ALLOC, 16'd17, 16'h0000);
    send_beat(KIND_ALLOC, 16'hFFFF, 16'h0000);
    send_beat(KIND_ALLOC, 16'd32768, 16'h0000);
    // biggest class, then heap too full for a second one
    send_beat(KIND_ALLOC, 16'd32767, 16'h0000);
    send_beat(KIND_ALLOC, 16'd32767, 16'h0000);
    send_beat(KIND_FREE, 16'd32767, 16'd88);
    send_beat(KIND_ALLOC, 16'd20000, 16'h0000);
    // frees: zero size, low address bits set, list pops in reverse order
    send_beat(KIND_FREE, 16'd0, 16'h0000);
    send_beat(KIND_FREE, 16'd8, 16'h000F);
    send_beat(KIND_ALLOC, 16'd5, 16'h0000);
    send_beat(KIND_ALLOC, 16'd0, 16'h0000);
    send_beat(KIND_FREE, 16'hFFFF, 16'hFFFF);
    send_beat(KIND_FREE, 16'd8, 16'hFFFF);
    send_beat(KIND_ALLOC, 16'd8, 16'h0000);
    // free with the wrong size, then a double free in the top class
    send_beat(KIND_FREE, 16'd100, 16'h0000);
    send_beat(KIND_ALLOC, 16'd128, 16'h0000);
    send_beat(KIND_FREE, 16'd20000, 16'h8000);
    send_beat(KIND_FREE, 16'd20000, 16'h8000);
    send_beat(KIND_ALLOC, 16'd20000, 16'h0000);
    send_beat(KIND_ALLOC, 16'd20000, 16'h0000);
    drain();

    // lowest threshold
    write_threshold(16'd16);
    send_beat(KIND_ALLOC, 16'd16, 16'h0000);
    send_beat(KIND_ALLOC, 16'd15, 16'h0000);
    send_beat(KIND_FREE, 16'd16, 16'h0040);
    drain();

    // random phases, each under its own threshold
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: thr = 16'd16;
        1: thr = 16'd32768;
        3: thr = 16'd1024;
        5: thr = THR_RESET;
        default: thr = SIZE_W'($urandom_range(16, 32768));
      endcase
      write_threshold(thr);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if (n % 40 == 0) begin
          quiet = ($urandom_range(0, 3) == 0);
        end
        random_beat();
      end
      drain();
    end

    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("pow2_size_class_allocator_core_tb passed");
    end else begin
      $display("pow2_size_class_allocator_core_tb failed");
    end
    $finish;
  end

endmodule
